@@ rtl/dipa_pkg.sv @@
// Shared types and constants for the dotted IPv4 address parser.
`timescale 1ns / 1ps
`default_nettype none

package dipa_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } item_t;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } result_t;

    typedef enum logic [3:0] {
        PH_DONE   = 4'b0001,
        PH_START  = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic       is_digit;
        logic       is_hex_alpha;
        logic       is_x;
        logic       is_zero;
        logic       is_dot;
        logic       is_term;
        logic [3:0] nibble;
    } char_class_t;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_UPPER_X  = 8'h58;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [3:0] ALPHA_BIAS  = 4'd9;

    localparam int         NUM_PARTS   = 4;
    localparam logic [2:0] MAX_PARTS   = 3'd4;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

@@ rtl/dipa_classify.sv @@
// Character classifier: digit, hex letter, prefix, dot and terminator decode.
`timescale 1ns / 1ps
`default_nettype none

module dipa_classify
(
    input  wire logic [7:0]           char_code,
    output dipa_pkg::char_class_t     cls
);

    always_comb
    begin
        cls.is_digit     = (char_code >= dipa_pkg::CH_0) && (char_code <= dipa_pkg::CH_9);
        cls.is_hex_alpha = ((char_code >= dipa_pkg::CH_LOWER_A) &&
                            (char_code <= dipa_pkg::CH_LOWER_F)) ||
                           ((char_code >= dipa_pkg::CH_UPPER_A) &&
                            (char_code <= dipa_pkg::CH_UPPER_F));
        cls.is_x         = (char_code == dipa_pkg::CH_LOWER_X) ||
                           (char_code == dipa_pkg::CH_UPPER_X);
        cls.is_zero      = (char_code == dipa_pkg::CH_0);
        cls.is_dot       = (char_code == dipa_pkg::CH_DOT);
        cls.is_term      = (char_code == dipa_pkg::CH_NUL) ||
                           (char_code == dipa_pkg::CH_SPACE) ||
                           ((char_code >= dipa_pkg::CH_TAB) && (char_code <= dipa_pkg::CH_CR));
        cls.nibble       = cls.is_digit ? char_code[3:0]
                                        : char_code[3:0] + dipa_pkg::ALPHA_BIAS;
    end

endmodule

`default_nettype wire

@@ rtl/dipa_engine.sv @@
// Parse state, stored parts and per-character update with address assembly.
`timescale 1ns / 1ps
`default_nettype none

module dipa_engine
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   start_req,
    input  wire dipa_pkg::char_class_t  cls,
    output logic                        res_valid,
    output dipa_pkg::result_t           res
);

    dipa_pkg::phase_t  phase_reg, phase_next;
    dipa_pkg::radix_t  radix_reg, radix_next;
    logic [31:0]       value_reg, value_next;
    logic [2:0]        count_reg, count_next;
    logic [31:0]       parts_reg [dipa_pkg::NUM_PARTS];

    dipa_pkg::phase_t  phase_eff;
    dipa_pkg::radix_t  radix_eff;
    logic [31:0]       value_eff;
    logic [2:0]        count_eff;
    logic              store_en;
    logic [31:0]       scaled;
    logic [31:0]       pv [dipa_pkg::NUM_PARTS];
    logic [31:0]       assembled;

    always_comb
    begin
        for (int i = 0; i < dipa_pkg::NUM_PARTS; i++)
        begin
            pv[i] = (count_eff[1:0] == i[1:0]) ? value_eff : parts_reg[i];
        end
        case (count_eff)
            3'd0:    assembled = pv[0];
            3'd1:    assembled = {pv[0][7:0], pv[1][23:0]};
            3'd2:    assembled = {pv[0][7:0], pv[1][7:0], pv[2][15:0]};
            default: assembled = {pv[0][7:0], pv[1][7:0], pv[2][7:0], pv[3][7:0]};
        endcase
    end

    always_comb
    begin
        logic cont;
        cont       = 1'b1;
        phase_eff  = start_req ? dipa_pkg::PH_START : phase_reg;
        radix_eff  = start_req ? dipa_pkg::RX_DEC : radix_reg;
        value_eff  = start_req ? 32'd0 : value_reg;
        count_eff  = start_req ? 3'd0 : count_reg;

        phase_next = phase_eff;
        radix_next = radix_eff;
        value_next = value_eff;
        count_next = count_eff;
        store_en   = 1'b0;
        res_valid  = 1'b0;
        res        = '{address: dipa_pkg::ALL_ONES, ok: 1'b0};
        scaled     = '0;

        case (phase_eff)
            dipa_pkg::PH_DONE:
            begin
                cont = 1'b0;
            end
            dipa_pkg::PH_START:
            begin
                if (cls.is_zero)
                begin
                    radix_next = dipa_pkg::RX_OCT;
                    phase_next = dipa_pkg::PH_ZERO;
                    cont       = 1'b0;
                end
                else if (cls.is_x)
                begin
                    radix_next = dipa_pkg::RX_HEX;
                    phase_next = dipa_pkg::PH_DIGITS;
                    cont       = 1'b0;
                end
                else
                begin
                    phase_next = dipa_pkg::PH_DIGITS;
                end
            end
            dipa_pkg::PH_ZERO:
            begin
                phase_next = dipa_pkg::PH_DIGITS;
                if (cls.is_x)
                begin
                    radix_next = dipa_pkg::RX_HEX;
                    cont       = 1'b0;
                end
            end
            default:
            begin
                cont = 1'b1;
            end
        endcase

        case (radix_next)
            dipa_pkg::RX_OCT: scaled = {value_eff[28:0], 3'b000};
            dipa_pkg::RX_HEX: scaled = {value_eff[27:0], 4'b0000};
            default:          scaled = {value_eff[28:0], 3'b000} + {value_eff[30:0], 1'b0};
        endcase

        if (cont)
        begin
            if (cls.is_digit || (cls.is_hex_alpha && (radix_next == dipa_pkg::RX_HEX)))
            begin
                value_next = scaled + {28'd0, cls.nibble};
            end
            else if (cls.is_dot && (count_eff < dipa_pkg::MAX_PARTS))
            begin
                store_en   = 1'b1;
                count_next = count_eff + 3'd1;
                value_next = 32'd0;
                radix_next = dipa_pkg::RX_DEC;
                phase_next = dipa_pkg::PH_START;
            end
            else if (cls.is_term && (count_eff < dipa_pkg::MAX_PARTS))
            begin
                store_en    = 1'b1;
                count_next  = count_eff + 3'd1;
                phase_next  = dipa_pkg::PH_DONE;
                res_valid   = 1'b1;
                res.address = assembled;
                res.ok      = 1'b1;
            end
            else
            begin
                phase_next = dipa_pkg::PH_DONE;
                res_valid  = 1'b1;
            end
        end

        if (!step)
        begin
            res_valid = 1'b0;
            store_en  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dipa_pkg::PH_DONE;
            radix_reg <= dipa_pkg::RX_DEC;
            value_reg <= 32'd0;
            count_reg <= 3'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            parts_reg[count_eff[1:0]] <= value_eff;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dotted_ipv4_address_parser_core.sv @@
// Top level of the dotted IPv4 address parser.
// Takes one character per cycle while the result is not stalled and transfers
// one result per parse, when the text ends or an invalid character arrives;
// each character passes an input register, one parse-state update and a result
// register, and the sustained rate is one character per cycle while the output
// is not stalled, set by the combinational update of the part value
// (shift-and-add by 8, 10 or 16).
// Characters seen while no parse is open are dropped; start_req opens a new parse.
`timescale 1ns / 1ps
`default_nettype none

module dotted_ipv4_address_parser_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire dipa_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output dipa_pkg::result_t       result
);

    logic                  hold_valid_reg;
    dipa_pkg::item_t       hold_reg;
    logic                  out_valid_reg;
    dipa_pkg::result_t     out_reg;
    logic                  advance;
    dipa_pkg::char_class_t cls;
    logic                  res_valid;
    dipa_pkg::result_t     res;

    assign advance      = hold_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = hold_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    dipa_classify u_classify
    (
        .char_code (hold_reg.char_code),
        .cls       (cls)
    );

    dipa_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .start_req (hold_reg.start_req),
        .cls       (cls),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            hold_reg <= item;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dipa_checker.sv @@
// Port-level checker for the dotted IPv4 address parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dipa_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire dipa_pkg::item_t    item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire dipa_pkg::result_t  result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input transfer changed");

    a_error_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ok |-> result.address == dipa_pkg::ALL_ONES)
        else $error("error result without all-ones address");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled while output free");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> $past(item_valid && !item_stall) || $past(item_stall))
        else $error("input stalled with no held transfer");

endmodule

bind dotted_ipv4_address_parser_core dipa_checker u_dipa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
